/* sv/rol_pkg.sv */
// ----------------------------------------------------------------------------
// rol_pkg
// Shared types and codes for the rest offset learner: iterative unit command
// and response words, register indexes, channel kinds and push events.
// ----------------------------------------------------------------------------
package rol_pkg;

	typedef logic [1:0] op_t;

	localparam op_t OP_DIV  = 2'd0;
	localparam op_t OP_MUL  = 2'd1;
	localparam op_t OP_SQRT = 2'd2;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [63:0] a;
		logic [31:0] b;
	} iter_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} iter_rsp_t;

	localparam logic [2:0] REG_CHANNEL_KIND      = 3'd0;
	localparam logic [2:0] REG_BURST_MODE        = 3'd1;
	localparam logic [2:0] REG_READY_THRESHOLD   = 3'd2;
	localparam logic [2:0] REG_REST_BAND         = 3'd3;
	localparam logic [2:0] REG_DRIFT_HOLD_US     = 3'd4;
	localparam logic [2:0] REG_DRIFT_COOLDOWN_US = 3'd5;

	localparam logic [1:0] KIND_PLAIN   = 2'd0;
	localparam logic [1:0] KIND_STICK   = 2'd1;
	localparam logic [1:0] KIND_TRIGGER = 2'd2;

	localparam logic [1:0] PUSH_NONE    = 2'd0;
	localparam logic [1:0] PUSH_ENABLE  = 2'd1;
	localparam logic [1:0] PUSH_DISABLE = 2'd2;

endpackage

/* sv/rol_iter_unit.sv */
// ----------------------------------------------------------------------------
// rol_iter_unit
// Shared bit-serial arithmetic unit: 64 by 32 restoring divide (64 steps),
// 32 by 32 shift-add multiply (32 steps) and 64-bit integer square root
// (32 steps, two radicand bits per step).
// ----------------------------------------------------------------------------
module rol_iter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  rol_pkg::iter_cmd_t  cmd,
	output rol_pkg::iter_rsp_t  rsp
);
	import rol_pkg::*;

	logic        busy_q;
	logic        done_q;
	op_t         op_q;
	logic [5:0]  cnt_q;
	logic [63:0] work_q;
	logic [35:0] rem_q;
	logic [63:0] res_q;
	logic [31:0] mlt_q;

	logic [33:0] div_shift;
	logic [33:0] div_diff;
	logic        div_ge;
	logic [35:0] sq_shift;
	logic [35:0] sq_trial;
	logic [35:0] sq_diff;
	logic        sq_ge;
	logic [5:0]  last_step;

	// one step of each operation
	always_comb begin
		div_shift = {rem_q[32:0], work_q[63]};
		div_diff  = div_shift - {2'b00, mlt_q};
		div_ge    = div_shift >= {2'b00, mlt_q};
		sq_shift  = {rem_q[33:0], work_q[63:62]};
		sq_trial  = {2'b00, res_q[31:0], 2'b01};
		sq_diff   = sq_shift - sq_trial;
		sq_ge     = sq_shift >= sq_trial;
		last_step = (op_q == OP_DIV) ? 6'd63 : 6'd31;
	end

	// control: busy flag, step counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_DIV;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= cmd.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			work_q <= cmd.a;
			mlt_q  <= cmd.b;
			rem_q  <= '0;
			res_q  <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				OP_DIV: begin
					rem_q  <= {3'b000, div_ge ? div_diff[32:0] : div_shift[32:0]};
					work_q <= {work_q[62:0], div_ge};
				end
				OP_MUL: begin
					if (mlt_q[0]) res_q <= res_q + work_q;
					work_q <= {work_q[62:0], 1'b0};
					mlt_q  <= {1'b0, mlt_q[31:1]};
				end
				OP_SQRT: begin
					rem_q  <= sq_ge ? sq_diff : sq_shift;
					res_q  <= {res_q[62:0], sq_ge};
					work_q <= {work_q[61:0], 2'b00};
				end
				default: begin
					work_q <= work_q;
				end
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == OP_DIV) ? work_q : res_q;

endmodule

/* sv/rest_offset_learner_with_drift_reset_core.sv */
// ----------------------------------------------------------------------------
// rest_offset_learner_with_drift_reset_core
// Rest offset learner for one analog channel with drift detection and relearn.
// ----------------------------------------------------------------------------
// One word in gives one result word out. A word whose sample is not at rest
// goes straight to the result; one at rest may feed the running mean (64-step
// divide, 32-step multiply), and while not ready the readiness check follows
// (64-step divide and 32-step square root); these all share one bit-serial
// unit. The block takes no new word while one is being worked on, but takes
// the next while a finished result still waits.
module rest_offset_learner_with_drift_reset_core #(
	parameter int SAMPLE_BITS = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic signed [SAMPLE_BITS-1:0] partner_value,
	input  logic                          partner_present,
	input  logic                          buttons_quiet,
	input  logic signed [SAMPLE_BITS-1:0] source_peak,
	input  logic                          max_valid,
	input  logic [TIME_BITS-1:0]          time_us,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_ready,
	output logic                          drift_pending,
	output logic [1:0]                    push_event,
	output logic signed [SAMPLE_BITS-1:0] rest_offset,
	output logic [SAMPLE_BITS-2:0]        rest_spread,
	output logic [11:0]                   trigger_floor,
	output logic [SAMPLE_BITS-2:0]        trigger_ceiling,
	output logic [11:0]                   dead_radius,
	output logic [31:0]                   rest_samples,
	output logic [15:0]                   relearn_count
);
	import rol_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int FRAC  = SAMPLE_BITS - 1;
	localparam int MS    = 32 - SAMPLE_BITS;
	localparam int FULL  = 2 ** FRAC;
	localparam int K_002 = (FULL * 2 + 50) / 100;
	localparam int K_005 = (FULL * 5 + 50) / 100;
	localparam int K_0001 = (FULL + 500) / 1000;
	localparam int K_010 = (FULL * 10 + 50) / 100;
	localparam int K_001 = (FULL + 50) / 100;
	localparam int K_008 = (FULL * 8 + 50) / 100;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EVAL  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_EMA   = 4'd4;
	localparam logic [3:0] ST_CHECK = 4'd5;
	localparam logic [3:0] ST_VDIV  = 4'd6;
	localparam logic [3:0] ST_SQRT  = 4'd7;
	localparam logic [3:0] ST_LEARN = 4'd8;
	localparam logic [3:0] ST_DRIFT = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	// configuration
	logic [1:0]  kind_q;
	logic        burst_q;
	logic [15:0] thr_q;
	logic [14:0] band_q;
	logic [31:0] hold_q;
	logic [31:0] cool_q;

	// latched input word
	logic signed [SB-1:0] s_q, p_q, om_q;
	logic                 pp_q, quiet_q, mv_q;
	logic [TIME_BITS-1:0] now_q;

	// learner state
	logic [3:0]            state_q;
	logic [31:0]           count_q;
	logic signed [31:0]    mean_q;
	logic [63:0]           sqdev_q;
	logic                  half_q;
	logic signed [31:0]    fm_q;
	logic                  fmv_q;
	logic signed [SB-1:0]  peak_q;
	logic                  ready_q, pend_q, exc_q;
	logic [TIME_BITS-1:0]  exc_start_q, cool_end_q;
	logic [15:0]           tally_q;
	logic signed [SB-1:0]  off_q;
	logic [FRAC-1:0]       spr_q, floor_q, ceil_q, dead_q;
	logic signed [32:0]    delta_q;
	logic [31:0]           sd_q;
	logic [1:0]            push_q;

	// output register
	logic                  ov_q;
	logic                  o_ready_q, o_pend_q;
	logic [1:0]            o_push_q;
	logic signed [SB-1:0]  o_off_q;
	logic [FRAC-1:0]       o_spr_q, o_floor_q, o_ceil_q, o_dead_q;
	logic [31:0]           o_count_q;
	logic [15:0]           o_tally_q;

	iter_cmd_t cmd_q;
	iter_rsp_t rsp;

	rol_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_q),
		.rsp    (rsp)
	);

	// rest test and peak tracking
	logic                 trig, stick, rest;
	logic signed [SB:0]   s_ext, p_ext;
	logic [SB:0]          abs_s, abs_p;
	logic                 s_in_band, p_in_band, trig_rest;
	logic signed [SB-1:0] peak_a, peak_b;
	logic signed [31:0]   x_w;

	always_comb begin
		trig      = kind_q == KIND_TRIGGER;
		stick     = kind_q == KIND_STICK;
		s_ext     = (SB+1)'(s_q);
		p_ext     = (SB+1)'(p_q);
		abs_s     = s_ext[SB] ? (SB+1)'(-s_ext) : (SB+1)'(s_ext);
		abs_p     = p_ext[SB] ? (SB+1)'(-p_ext) : (SB+1)'(p_ext);
		s_in_band = 32'(abs_s) < 32'(band_q);
		p_in_band = 32'(abs_p) < 32'(band_q);
		trig_rest = 33'(s_q) < $signed({18'd0, band_q});
		if (stick)     rest = pp_q && s_in_band && p_in_band && quiet_q;
		else if (trig) rest = trig_rest;
		else           rest = s_in_band && quiet_q;
		peak_a = (s_q > peak_q) ? s_q : peak_q;
		peak_b = (mv_q && om_q > peak_a) ? om_q : peak_a;
		x_w    = $signed({s_q, {MS{1'b0}}});
	end

	// welford step, deviation sum and fast mean arithmetic
	logic               do_w;
	logic signed [32:0] delta_w;
	logic [31:0]        abs_delta_w;
	logic signed [32:0] quo_s;
	logic signed [32:0] step_w;
	logic signed [32:0] rem_w;
	logic [31:0]        abs_rem_w;
	logic [63:0]        dev_sh;
	logic [64:0]        dev_sum;
	logic signed [32:0] ema_d;
	logic [31:0]        ema_abs;
	logic [43:0]        ema_mag;
	logic [31:0]        abs_dq;

	always_comb begin
		do_w        = burst_q || half_q;
		delta_w     = 33'(x_w) - 33'(mean_q);
		abs_delta_w = delta_w[32] ? 32'(-delta_w) : delta_w[31:0];
		quo_s       = $signed(rsp.result[32:0]);
		step_w      = delta_q[32] ? -quo_s : quo_s;
		rem_w       = delta_q - step_w;
		abs_rem_w   = rem_w[32] ? 32'(-rem_w) : rem_w[31:0];
		abs_dq      = delta_q[32] ? 32'(-delta_q) : delta_q[31:0];
		dev_sh      = rsp.result >> (2 * MS);
		dev_sum     = {1'b0, sqdev_q} + {1'b0, dev_sh};
		ema_d       = 33'(x_w) - 33'(fm_q);
		ema_abs     = ema_d[32] ? 32'(-ema_d) : ema_d[31:0];
		ema_mag     = (44'(ema_abs) * 44'(3277) + 44'(32768)) >> 16;
	end

	// learned values
	logic signed [32:0]   m_rnd, m_shr;
	logic signed [SB-1:0] mean_r;
	logic [FRAC-1:0]      floor_w, ceil_w, dead_w, sd_cap;
	logic [33:0]          sd3;
	logic [31:0]          lim;

	always_comb begin
		m_rnd   = 33'(mean_q) + 33'(2 ** (MS - 1));
		m_shr   = m_rnd >>> MS;
		mean_r  = (m_shr > 33'(FULL - 1)) ? SB'(FULL - 1) : m_shr[SB-1:0];
		if (mean_r < 0)                  floor_w = '0;
		else if (mean_r > SB'(K_010))    floor_w = FRAC'(K_010);
		else                             floor_w = mean_r[FRAC-1:0];
		ceil_w  = (peak_q > SB'(K_010)) ? peak_q[FRAC-1:0] : FRAC'(FULL - 1);
		sd3     = 34'(sd_q) * 34'(3);
		if (sd3 < 34'(K_001))            dead_w = FRAC'(K_001);
		else if (sd3 > 34'(K_008))       dead_w = FRAC'(K_008);
		else                             dead_w = sd3[FRAC-1:0];
		sd_cap  = (sd_q > 32'(FULL - 1)) ? FRAC'(FULL - 1) : sd_q[FRAC-1:0];
		lim     = trig ? 32'(K_005) : 32'(K_002);
	end

	// drift gate and hold timer
	logic [FRAC-1:0]      sd_eff;
	logic [33:0]          gate;
	logic signed [32:0]   diff;
	logic [32:0]          abs_diff;
	logic                 drift_now;
	logic [TIME_BITS-1:0] start_eff, elapsed;

	always_comb begin
		sd_eff    = (spr_q > FRAC'(K_0001)) ? spr_q : FRAC'(K_0001);
		gate      = (34'(sd_eff) * 34'(3)) << MS;
		diff      = 33'(fm_q) - 33'($signed({off_q, {MS{1'b0}}}));
		abs_diff  = diff[32] ? 33'(-diff) : 33'(diff);
		drift_now = (now_q >= cool_end_q) && (34'(abs_diff) > gate);
		start_eff = exc_q ? exc_start_q : now_q;
		elapsed   = now_q - start_eff;
	end

	assign in_ready = state_q == ST_IDLE;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_PLAIN;
			burst_q <= 1'b0;
			thr_q   <= 16'd1024;
			band_q  <= 15'd1638;
			hold_q  <= 32'd10000000;
			cool_q  <= 32'd60000000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL_KIND:      kind_q  <= cfg_data[1:0];
				REG_BURST_MODE:        burst_q <= cfg_data[0];
				REG_READY_THRESHOLD:   thr_q   <= cfg_data[15:0];
				REG_REST_BAND:         band_q  <= cfg_data[14:0];
				REG_DRIFT_HOLD_US:     hold_q  <= cfg_data;
				REG_DRIFT_COOLDOWN_US: cool_q  <= cfg_data;
				default:               kind_q  <= kind_q;
			endcase
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s_q     <= sample_value;
			p_q     <= partner_value;
			pp_q    <= partner_present;
			quiet_q <= buttons_quiet;
			om_q    <= source_peak;
			mv_q    <= max_valid;
			now_q   <= time_us;
		end
	end

	// sequencer and learner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			mean_q      <= '0;
			sqdev_q     <= '0;
			half_q      <= 1'b0;
			fm_q        <= '0;
			fmv_q       <= 1'b0;
			peak_q      <= '0;
			ready_q     <= 1'b0;
			pend_q      <= 1'b0;
			exc_q       <= 1'b0;
			exc_start_q <= '0;
			cool_end_q  <= '0;
			tally_q     <= '0;
			off_q       <= '0;
			spr_q       <= '0;
			floor_q     <= '0;
			ceil_q      <= '0;
			dead_q      <= '0;
			push_q      <= PUSH_NONE;
			cmd_q       <= '0;
			ov_q        <= 1'b0;
		end else begin
			// result valid: set when a word is loaded, cleared when taken
			if (state_q == ST_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready)                            ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cmd_q.start <= 1'b0;
					if (in_valid) begin
						push_q  <= PUSH_NONE;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (trig) peak_q <= peak_b;
					if (!rest) begin
						cmd_q.start <= 1'b0;
						state_q     <= ST_OUT;
					end else begin
						if (!burst_q) half_q <= !half_q;
						if (do_w && count_q != '1) begin
							count_q     <= count_q + 32'd1;
							delta_q     <= delta_w;
							cmd_q.start <= 1'b1;
							cmd_q.op    <= OP_DIV;
							cmd_q.a     <= 64'(abs_delta_w);
							cmd_q.b     <= count_q + 32'd1;
							state_q     <= ST_DIV;
						end else begin
							cmd_q.start <= 1'b0;
							state_q     <= ST_EMA;
						end
					end
				end
				ST_DIV: begin
					cmd_q.start <= rsp.done;
					if (rsp.done) begin
						mean_q   <= mean_q + step_w[31:0];
						cmd_q.op <= OP_MUL;
						cmd_q.a  <= 64'(abs_dq);
						cmd_q.b  <= abs_rem_w;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					cmd_q.start <= 1'b0;
					if (rsp.done) begin
						sqdev_q <= dev_sum[64] ? '1 : dev_sum[63:0];
						state_q <= ST_EMA;
					end
				end
				ST_EMA: begin
					cmd_q.start <= 1'b0;
					if (!fmv_q) begin
						fm_q  <= x_w;
						fmv_q <= 1'b1;
					end else if (ema_d[32]) begin
						fm_q <= fm_q - $signed(32'(ema_mag));
					end else begin
						fm_q <= fm_q + $signed(32'(ema_mag));
					end
					state_q <= ready_q ? ST_DRIFT : ST_CHECK;
				end
				ST_CHECK: begin
					if (count_q < 32'(thr_q)) begin
						cmd_q.start <= 1'b0;
						state_q     <= ST_OUT;
					end else if (count_q < 32'd2) begin
						cmd_q.start <= 1'b0;
						sd_q        <= '0;
						state_q     <= ST_LEARN;
					end else begin
						cmd_q.start <= 1'b1;
						cmd_q.op    <= OP_DIV;
						cmd_q.a     <= sqdev_q;
						cmd_q.b     <= count_q - 32'd1;
						state_q     <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					cmd_q.start <= rsp.done;
					if (rsp.done) begin
						cmd_q.op <= OP_SQRT;
						cmd_q.a  <= rsp.result;
						state_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cmd_q.start <= 1'b0;
					if (rsp.done) begin
						sd_q    <= rsp.result[31:0];
						state_q <= ST_LEARN;
					end
				end
				ST_LEARN: begin
					cmd_q.start <= 1'b0;
					if (sd_q < lim) begin
						ready_q <= 1'b1;
						pend_q  <= 1'b0;
						off_q   <= mean_r;
						spr_q   <= sd_cap;
						if (trig) begin
							floor_q <= floor_w;
							ceil_q  <= ceil_w;
						end
						if (stick) dead_q <= dead_w;
						push_q <= PUSH_ENABLE;
					end
					state_q <= ST_OUT;
				end
				ST_DRIFT: begin
					cmd_q.start <= 1'b0;
					if (drift_now) begin
						if (elapsed >= TIME_BITS'(hold_q)) begin
							ready_q     <= 1'b0;
							pend_q      <= 1'b1;
							exc_q       <= 1'b0;
							exc_start_q <= '0;
							cool_end_q  <= now_q + TIME_BITS'(cool_q);
							if (tally_q != '1) tally_q <= tally_q + 16'd1;
							count_q     <= '0;
							mean_q      <= '0;
							sqdev_q     <= '0;
							half_q      <= 1'b0;
							fm_q        <= '0;
							fmv_q       <= 1'b0;
							off_q       <= '0;
							spr_q       <= '0;
							floor_q     <= '0;
							ceil_q      <= '0;
							dead_q      <= '0;
							push_q      <= PUSH_DISABLE;
						end else begin
							exc_q       <= 1'b1;
							exc_start_q <= start_eff;
						end
					end else begin
						exc_q       <= 1'b0;
						exc_start_q <= '0;
						pend_q      <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					cmd_q.start <= 1'b0;
					if (!ov_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					cmd_q.start <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!ov_q || out_ready)) begin
			o_ready_q <= ready_q;
			o_pend_q  <= pend_q;
			o_push_q  <= push_q;
			o_off_q   <= off_q;
			o_spr_q   <= spr_q;
			o_floor_q <= floor_q;
			o_ceil_q  <= ceil_q;
			o_dead_q  <= dead_q;
			o_count_q <= count_q;
			o_tally_q <= tally_q;
		end
	end

	logic [31:0] floor_ext, dead_ext;

	always_comb begin
		floor_ext = 32'(o_floor_q);
		dead_ext  = 32'(o_dead_q);
	end

	assign out_valid       = ov_q;
	assign is_ready        = o_ready_q;
	assign drift_pending   = o_pend_q;
	assign push_event      = o_push_q;
	assign rest_offset     = o_off_q;
	assign rest_spread     = o_spr_q;
	assign trigger_floor   = floor_ext[11:0];
	assign trigger_ceiling = o_ceil_q;
	assign dead_radius     = dead_ext[11:0];
	assign rest_samples    = o_count_q;
	assign relearn_count   = o_tally_q;

endmodule
